### design/xml_entity_decoder_macros.svh
// assertion macros used by the xml entity decoder
`ifndef XML_ENTITY_DECODER_MACROS_SVH
`define XML_ENTITY_DECODER_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define XED_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("xml entity decoder: same-cycle check failed");

// next-cycle implication, checked on every rising clock edge outside reset
`define XED_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("xml entity decoder: next-cycle check failed");

`endif

### design/xed_pkg.sv
// types, sizes and entity tables of the xml entity decoder
package xed_pkg;

	typedef logic [7:0] byte_t;

	// hold depth after the ampersand and the most words one byte can cause
	localparam int HOLD_DEPTH = 4;
	localparam int MAX_RES    = 6;
	localparam int NUM_ENT    = 5;
	localparam int ENT_MAX    = 5;

	localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
	localparam int RES_W = $clog2(MAX_RES + 1);
	localparam int IDX_W = $clog2(MAX_RES);

	localparam byte_t AMP = "&";

	// entity bodies after the ampersand, their lengths and decoded characters
	localparam byte_t ENT_BODY [NUM_ENT][ENT_MAX] = '{
		'{"l", "t", ";", 8'h00, 8'h00},
		'{"g", "t", ";", 8'h00, 8'h00},
		'{"a", "p", "o", "s", ";"},
		'{"a", "m", "p", ";", 8'h00},
		'{"q", "u", "o", "t", ";"}
	};
	localparam logic [CNT_W-1:0] ENT_LEN [NUM_ENT] = '{3'd3, 3'd3, 3'd5, 3'd4, 3'd5};
	localparam byte_t ENT_CHAR [NUM_ENT] = '{"<", ">", 8'h27, "&", 8'h22};

	// matching state: alive marks entities still consistent with the held bytes
	typedef struct packed {
		logic                          ent;
		logic [CNT_W-1:0]              cnt;
		logic [NUM_ENT-1:0]            alive;
		logic [HOLD_DEPTH-1:0][7:0]    held;
	} xed_state_t;

	// words caused by one input byte, in order from slot 0
	typedef struct packed {
		logic [MAX_RES-1:0][7:0] chars;
		logic [RES_W-1:0]        count;
	} xed_result_t;

endpackage

### design/xed_match.sv
// entity matcher: next state and output words for one input byte
module xed_match (
	input  xed_pkg::byte_t      c,
	input  logic                fin,
	input  xed_pkg::xed_state_t cur,
	output xed_pkg::xed_state_t nxt,
	output xed_pkg::xed_result_t res
);

	logic                          full;
	logic                          pre;
	xed_pkg::byte_t                dec;
	logic [xed_pkg::NUM_ENT-1:0]   alive_n;
	logic [xed_pkg::RES_W-1:0]     k;

	// compare the new byte against every entity still alive
	always_comb begin
		full    = 1'b0;
		pre     = 1'b0;
		dec     = '0;
		alive_n = '0;
		for (int e = 0; e < xed_pkg::NUM_ENT; e++) begin
			if (cur.alive[e] && cur.cnt < xed_pkg::ENT_LEN[e] &&
			    c == xed_pkg::ENT_BODY[e][cur.cnt]) begin
				alive_n[e] = 1'b1;
				if (cur.cnt + 3'd1 == xed_pkg::ENT_LEN[e]) begin
					full = 1'b1;
					dec  = xed_pkg::ENT_CHAR[e];
				end else begin
					pre = 1'b1;
				end
			end
		end
	end

	// build the word list and the next state
	always_comb begin
		nxt       = cur;
		res.chars = '0;
		k         = '0;
		if (!cur.ent) begin
			if (c == xed_pkg::AMP) begin
				nxt.ent   = 1'b1;
				nxt.cnt   = '0;
				nxt.alive = '1;
			end else begin
				res.chars[k] = c;
				k = k + 1'b1;
			end
		end else if (full) begin
			res.chars[k] = dec;
			k = k + 1'b1;
			nxt.ent = 1'b0;
			nxt.cnt = '0;
		end else if (pre && cur.cnt < xed_pkg::HOLD_DEPTH) begin
			nxt.held[cur.cnt[1:0]] = c;
			nxt.cnt   = cur.cnt + 1'b1;
			nxt.alive = alive_n;
		end else begin
			// failed match: ampersand and held bytes go out unchanged, then the new byte unless it opens a new entity
			res.chars[k] = xed_pkg::AMP;
			k = k + 1'b1;
			for (int i = 0; i < xed_pkg::HOLD_DEPTH; i++) begin
				if (i < cur.cnt) begin
					res.chars[k] = cur.held[i];
					k = k + 1'b1;
				end
			end
			nxt.cnt = '0;
			if (c == xed_pkg::AMP) begin
				nxt.ent   = 1'b1;
				nxt.alive = '1;
			end else begin
				res.chars[k] = c;
				k = k + 1'b1;
				nxt.ent = 1'b0;
			end
		end

		// last byte of the stream flushes whatever is still held
		if (fin) begin
			if (nxt.ent) begin
				res.chars[k] = xed_pkg::AMP;
				k = k + 1'b1;
				for (int i = 0; i < xed_pkg::HOLD_DEPTH; i++) begin
					if (i < nxt.cnt) begin
						res.chars[k] = nxt.held[i];
						k = k + 1'b1;
					end
				end
			end
			nxt.ent = 1'b0;
			nxt.cnt = '0;
		end
		res.count = k;
	end

endmodule

### design/xml_entity_decoder.sv
// Decodes the five predefined XML entities in a byte stream, one byte word per
// cycle while m_tready is high. A byte held as part of a possible entity causes
// no output; a byte that causes more than one output holds the input side while
// the result buffer drains, at most six words (a failed match after four held
// bytes). The result buffer is the only stage: a new byte is accepted in the same
// cycle that the last word of the previous byte is taken.
`include "xml_entity_decoder_macros.svh"

module xml_entity_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] in_char
	input  logic       s_tlast,  // in_final
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] out_char
	output logic       m_tlast,  // run_end
	output logic       m_tuser   // [0] stream_end
);

	xed_pkg::xed_state_t             st_q;
	xed_pkg::xed_state_t             st_nxt;
	xed_pkg::xed_result_t            res;
	logic [xed_pkg::MAX_RES-1:0][7:0] res_s1;
	logic [xed_pkg::IDX_W-1:0]       last_s1;
	logic                            fin_s1;
	logic [xed_pkg::IDX_W-1:0]       idx_q;
	logic                            busy_q;
	logic                            accept;
	logic                            take;
	logic                            take_last;

	xed_match u_match (
		.c   (s_tdata),
		.fin (s_tlast),
		.cur (st_q),
		.nxt (st_nxt),
		.res (res)
	);

	// handshake
	assign take      = m_tvalid && m_tready;
	assign take_last = take && m_tlast;
	assign s_tready  = !busy_q || take_last;
	assign accept    = s_tvalid && s_tready;

	// output word from the result buffer
	assign m_tvalid = busy_q;
	assign m_tdata  = res_s1[idx_q];
	assign m_tlast  = idx_q == last_s1;
	assign m_tuser  = fin_s1 && m_tlast;

	// matching state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (accept) begin
			st_q <= st_nxt;
		end
	end

	// buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (accept) begin
			busy_q <= res.count != '0;
			idx_q  <= '0;
		end else if (take) begin
			if (m_tlast) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// buffer payload
	always_ff @(posedge clk) begin
		if (accept && res.count != '0) begin
			res_s1  <= res.chars;
			last_s1 <= xed_pkg::IDX_W'(res.count - 1'b1);
			fin_s1  <= s_tlast;
		end
	end

	// checks
	`XED_ASSERT_IMP(a_idx_range, clk, arst_n, m_tvalid, idx_q <= last_s1)
	`XED_ASSERT_IMP(a_no_overrun, clk, arst_n, accept && m_tvalid, take_last)
	`XED_ASSERT_IMP(a_hold_range, clk, arst_n, 1'b1, st_q.cnt <= xed_pkg::HOLD_DEPTH)
	`XED_ASSERT_NXT(a_flush_idle, clk, arst_n, accept && s_tlast, !st_q.ent && st_q.cnt == '0)

endmodule
